### hdl/ptag_pkg.sv
// ----------------------------------------------------------------------------
// ptag_pkg: shared definitions for the pixel tone adjust block
// Channel widths, luminance coefficients, register indexes and the
// control bundle that the top level hands to the lanes and the merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

package ptag_pkg;

  localparam int ChanW = 8;
  localparam int CoefW = 16;
  localparam int ProdW = ChanW + CoefW;
  localparam int OffW  = 9;

  // Luminance weights in unsigned Q0.16; they sum to exactly one.
  localparam logic [CoefW-1:0] LUMA_R = 16'd19595;
  localparam logic [CoefW-1:0] LUMA_G = 16'd38470;
  localparam logic [CoefW-1:0] LUMA_B = 16'd7471;

  typedef enum logic [1:0] {
    REG_RED_OFF   = 2'd0,
    REG_GREEN_OFF = 2'd1,
    REG_BLUE_OFF  = 2'd2,
    REG_GRAY      = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic adv;        // every pipeline stage moves one step
    logic gray_mode;  // desaturation path selected
  } pipe_ctrl_t;

endpackage : ptag_pkg

`default_nettype wire

### hdl/pixel_tone_adjust_with_gray_unit.sv
// ----------------------------------------------------------------------------
// pixel_tone_adjust_with_gray_unit: RGBA tone offset with desaturation
// Top level: configuration registers, three channel lanes, the luminance
// merge stage and the pipeline handshake.
// ----------------------------------------------------------------------------
// The block takes one RGBA pixel per clock and returns one toned pixel per
// clock as long as the output side takes results. Each channel lane has four
// stages: weighted product, luminance merge, multiply by the gray factor, and
// offset with rounding and clamping into the output register. With the gray
// amount at zero each channel simply gets its signed offset and is clamped
// to 0..255; otherwise each channel is pulled toward the pixel luminance
// before the offset. Alpha travels alongside unchanged. The user must write
// the registers over the APB-style port only while no transaction is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_tone_adjust_with_gray_unit
  import ptag_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  // Pixel input channel.
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire [ChanW-1:0]  pixel_red_i,
  input  wire [ChanW-1:0]  pixel_green_i,
  input  wire [ChanW-1:0]  pixel_blue_i,
  input  wire [ChanW-1:0]  pixel_alpha_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic [ChanW-1:0] toned_red_o,
  output logic [ChanW-1:0] toned_green_o,
  output logic [ChanW-1:0] toned_blue_o,
  output logic [ChanW-1:0] toned_alpha_o,
  // Configuration port.
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire [3:0]        paddr,
  input  wire [31:0]       pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int Stages = 4;

  // Configuration registers.
  logic signed [OffW-1:0] off_r_q, off_g_q, off_b_q;
  logic [ChanW-1:0]       gray_q;
  logic                   cfg_wr;
  reg_idx_e               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_r_q <= '0;
      off_g_q <= '0;
      off_b_q <= '0;
      gray_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RED_OFF:   off_r_q <= $signed(pwdata[OffW-1:0]);
        REG_GREEN_OFF: off_g_q <= $signed(pwdata[OffW-1:0]);
        REG_BLUE_OFF:  off_b_q <= $signed(pwdata[OffW-1:0]);
        REG_GRAY:      gray_q  <= pwdata[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // Offsets read back sign extended to the bus width.
  always_comb begin
    case (cfg_idx)
      REG_RED_OFF:   prdata = 32'(off_r_q);
      REG_GREEN_OFF: prdata = 32'(off_g_q);
      REG_BLUE_OFF:  prdata = 32'(off_b_q);
      REG_GRAY:      prdata = {24'd0, gray_q};
      default:       prdata = '0;
    endcase
  end

  // Gray factor round((255 - gray) * 65536 / 255). Since 65536 is
  // 255 * 257 + 1, this is k * 257 plus one when k is 128 or more, with
  // k = 255 - gray. Plain offset mode does not use it, so the wrap at a gray
  // amount of zero is harmless.
  logic [ChanW-1:0] gray_k;
  logic [CoefW-1:0] factor;

  assign gray_k = ChanW'(8'd255 - gray_q);
  assign factor = {gray_k, gray_k} + CoefW'(gray_k[ChanW-1]);

  // Pipeline control. All stages move together; a result that is not taken
  // freezes the whole pipe, bubbles included, until the output side takes it.
  logic [Stages-1:0] vld_q;
  pipe_ctrl_t        ctrl;

  assign ctrl.adv       = out_ready_i | ~vld_q[Stages-1];
  assign ctrl.gray_mode = (gray_q != '0);
  assign in_ready_o     = ctrl.adv;
  assign out_valid_o    = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctrl.adv) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  // Alpha rides along in a plain delay line matching the lane depth.
  logic [ChanW-1:0] alpha_q [Stages];

  always_ff @(posedge clk_i) begin
    if (ctrl.adv) begin
      alpha_q[0] <= pixel_alpha_i;
      for (int s = 1; s < Stages; s++) begin
        alpha_q[s] <= alpha_q[s-1];
      end
    end
  end

  assign toned_alpha_o = alpha_q[Stages-1];

  // Channel lanes and the luminance merge between them.
  logic [ProdW-1:0] prod_r, prod_g, prod_b, lum;

  ptag_lane u_lane_r (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .chan_i      (pixel_red_i),
    .luma_coef_i (LUMA_R),
    .lum_i       (lum),
    .factor_i    (factor),
    .offset_i    (off_r_q),
    .prod_o      (prod_r),
    .chan_o      (toned_red_o)
  );

  ptag_lane u_lane_g (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .chan_i      (pixel_green_i),
    .luma_coef_i (LUMA_G),
    .lum_i       (lum),
    .factor_i    (factor),
    .offset_i    (off_g_q),
    .prod_o      (prod_g),
    .chan_o      (toned_green_o)
  );

  ptag_lane u_lane_b (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .chan_i      (pixel_blue_i),
    .luma_coef_i (LUMA_B),
    .lum_i       (lum),
    .factor_i    (factor),
    .offset_i    (off_b_q),
    .prod_o      (prod_b),
    .chan_o      (toned_blue_o)
  );

  ptag_luma_merge u_merge (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .prod_r_i (prod_r),
    .prod_g_i (prod_g),
    .prod_b_i (prod_b),
    .lum_o    (lum)
  );

`ifndef SYNTHESIS
  // The input side may only be held off by a result that is not taken.
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (out_ready_i || !out_valid_o))
    else $error("input ready does not follow the output stall");

  // An accepted transaction always occupies the first stage next cycle.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted transaction missing from the first stage");

  // A stall freezes every stage so that nothing is lost or duplicated.
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl.adv |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

  // A gray amount write lands in the register.
  a_gray_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (cfg_idx == REG_GRAY) |=> gray_q == $past(pwdata[ChanW-1:0]))
    else $error("gray amount write lost");
`endif

endmodule : pixel_tone_adjust_with_gray_unit

`default_nettype wire

### hdl/ptag_luma_merge.sv
// ----------------------------------------------------------------------------
// ptag_luma_merge: luminance merge stage
// Sums the three weighted channel products from the lanes into one registered
// Q8.16 luminance that every lane then uses.
// ----------------------------------------------------------------------------
`default_nettype none

module ptag_luma_merge
  import ptag_pkg::*;
(
  input  wire              clk_i,
  input  wire pipe_ctrl_t  ctrl_i,
  input  wire [ProdW-1:0]  prod_r_i,
  input  wire [ProdW-1:0]  prod_g_i,
  input  wire [ProdW-1:0]  prod_b_i,
  output logic [ProdW-1:0] lum_o
);

  logic [ProdW-1:0] lum_d;
  logic [ProdW-1:0] lum_q;

  // The weights sum to one, so the total never exceeds 255 in Q8.16.
  assign lum_d = prod_r_i + prod_g_i + prod_b_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      lum_q <= lum_d;
    end
  end

  assign lum_o = lum_q;

endmodule : ptag_luma_merge

`default_nettype wire

### hdl/ptag_lane.sv
// ----------------------------------------------------------------------------
// ptag_lane: one color channel lane
// Four stages: weighted product, wait for luminance, pull toward luminance,
// then offset, round and clamp into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptag_lane
  import ptag_pkg::*;
(
  input  wire                    clk_i,
  input  wire pipe_ctrl_t        ctrl_i,
  input  wire [ChanW-1:0]        chan_i,
  input  wire [CoefW-1:0]        luma_coef_i,
  input  wire [ProdW-1:0]        lum_i,
  input  wire [CoefW-1:0]        factor_i,
  input  wire signed [OffW-1:0]  offset_i,
  output logic [ProdW-1:0]       prod_o,
  output logic [ChanW-1:0]       chan_o
);

  localparam int DiffW = ProdW + 1;
  localparam int MulW  = DiffW + CoefW + 1;
  localparam int SumW  = MulW + 2;
  localparam int QW    = SumW - 32;

  logic [ChanW-1:0]        c1_q, c2_q, c3_q;
  logic [ProdW-1:0]        p1_q, l3_q;
  logic signed [MulW-1:0]  m3_q;
  logic [ChanW-1:0]        out_q;

  logic signed [DiffW-1:0] diff;
  logic signed [MulW-1:0]  m3_d;
  logic signed [SumW-1:0]  v;
  logic signed [QW-1:0]    q;
  logic signed [ChanW+1:0] plain;
  logic [ChanW-1:0]        gray_res, plain_res, out_d;

  // Distance from the luminance, signed Q8.16.
  assign diff = $signed({1'b0, c2_q, {CoefW{1'b0}}}) - $signed({1'b0, lum_i});
  assign m3_d = MulW'(diff) * MulW'($signed({1'b0, factor_i}));

  // Signed Q11.32 sum with the rounding half added, then floor by taking the top bits.
  assign v = SumW'(m3_q)
           + $signed({{(SumW-ProdW-CoefW){1'b0}}, l3_q, {CoefW{1'b0}}})
           + $signed({{(SumW-OffW-32){offset_i[OffW-1]}}, offset_i, 32'd0})
           + $signed({{(SumW-32){1'b0}}, 1'b1, 31'd0});
  assign q = v[SumW-1:32];

  always_comb begin
    if (q < 0) begin
      gray_res = '0;
    end else if (q > $signed(QW'(255))) begin
      gray_res = '1;
    end else begin
      gray_res = q[ChanW-1:0];
    end
  end

  assign plain = $signed({2'b00, c3_q}) + $signed({offset_i[OffW-1], offset_i});

  always_comb begin
    if (plain < 0) begin
      plain_res = '0;
    end else if (plain > $signed((ChanW+2)'(255))) begin
      plain_res = '1;
    end else begin
      plain_res = plain[ChanW-1:0];
    end
  end

  assign out_d = ctrl_i.gray_mode ? gray_res : plain_res;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      c1_q  <= chan_i;
      p1_q  <= ProdW'(chan_i) * luma_coef_i;
      c2_q  <= c1_q;
      c3_q  <= c2_q;
      l3_q  <= lum_i;
      m3_q  <= m3_d;
      out_q <= out_d;
    end
  end

  assign prod_o = p1_q;
  assign chan_o = out_q;

endmodule : ptag_lane

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for pixel_tone_adjust_with_gray_unit
// Drives RGBA pixels through the valid/ready input channel, programs the tone
// registers over the APB-style port, predicts every toned pixel in the
// testbench and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------

module tb_top;
  import ptag_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int MaxGap        = 200;
  localparam int DrainCycles   = 10;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } toned_pixel_t;

  // Every input of the block starts at a known value.
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic [ChanW-1:0] pixel_red_i   = '0;
  logic [ChanW-1:0] pixel_green_i = '0;
  logic [ChanW-1:0] pixel_blue_i  = '0;
  logic [ChanW-1:0] pixel_alpha_i = '0;
  logic             out_ready_i   = 1'b0;
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [3:0]       paddr         = '0;
  logic [31:0]      pwdata        = '0;

  logic             in_ready_o;
  logic             out_valid_o;
  logic [ChanW-1:0] toned_red_o;
  logic [ChanW-1:0] toned_green_o;
  logic [ChanW-1:0] toned_blue_o;
  logic [ChanW-1:0] toned_alpha_o;
  logic [31:0]      prdata;
  logic             pready;

  // Testbench copy of the tone registers, updated when a write lands.
  logic signed [OffW-1:0] red_offset;
  logic signed [OffW-1:0] green_offset;
  logic signed [OffW-1:0] blue_offset;
  logic [ChanW-1:0]       gray_amount;

  // Toned pixels that the block still owes us, oldest first.
  toned_pixel_t toned_pixel_q[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int pixels_sent = 0;
  int pixels_checked = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  pixel_tone_adjust_with_gray_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_red_i   (pixel_red_i),
    .pixel_green_i (pixel_green_i),
    .pixel_blue_i  (pixel_blue_i),
    .pixel_alpha_i (pixel_alpha_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .toned_red_o   (toned_red_o),
    .toned_green_o (toned_green_o),
    .toned_blue_o  (toned_blue_o),
    .toned_alpha_o (toned_alpha_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Tone predictor
  // --------------------------------------------------------------------------

  // Mirrors a register write. Only the low bits of the data word count: nine
  // for an offset, taken as two's complement, and eight for the gray amount.
  function automatic void apply_tone_write(reg_idx_e idx, logic [31:0] data);
    case (idx)
      REG_RED_OFF:   red_offset   = data[OffW-1:0];
      REG_GREEN_OFF: green_offset = data[OffW-1:0];
      REG_BLUE_OFF:  blue_offset  = data[OffW-1:0];
      REG_GRAY:      gray_amount  = data[ChanW-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [ChanW-1:0] clamp_channel(longint value);
    if (value < 0) begin
      return '0;
    end else if (value > 255) begin
      return 8'hff;
    end
    return value[ChanW-1:0];
  endfunction

  // One color channel. In gray mode everything is carried in signed Q31.32 so the
  // blend, the offset and the half-up rounding are exact before the floor.
  function automatic logic [ChanW-1:0] tone_channel(logic [ChanW-1:0] chan,
                                                    longint luma,
                                                    logic signed [OffW-1:0] offset);
    longint c;
    longint off;
    longint gray;
    longint factor;
    longint blend;
    c    = longint'(chan);
    off  = longint'(offset);
    gray = longint'(gray_amount);
    if (gray == 0) begin
      return clamp_channel(c + off);
    end
    // Pull factor (255 - gray) / 255 in Q0.16, rounded half up.
    factor = ((255 - gray) * 65536 + 127) / 255;
    blend  = (c * 65536 - luma) * factor + luma * 65536 + off * (64'sd1 <<< 32)
             + (64'sd1 <<< 31);
    if (blend < 0) begin
      return '0;
    end
    return clamp_channel(blend >>> 32);
  endfunction

  function automatic toned_pixel_t predict_toned(logic [ChanW-1:0] red,
                                                 logic [ChanW-1:0] green,
                                                 logic [ChanW-1:0] blue,
                                                 logic [ChanW-1:0] alpha);
    toned_pixel_t px;
    longint luma;
    luma = longint'(red) * longint'(LUMA_R) + longint'(green) * longint'(LUMA_G)
           + longint'(blue) * longint'(LUMA_B);
    px.red   = tone_channel(red, luma, red_offset);
    px.green = tone_channel(green, luma, green_offset);
    px.blue  = tone_channel(blue, luma, blue_offset);
    px.alpha = alpha;
    return px;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and checker
  // --------------------------------------------------------------------------

  task automatic check_field(string name, logic [ChanW-1:0] want, logic [ChanW-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
    end
  endtask

  // Both channels are sampled in one process at the clock edge. An accepted
  // pixel is predicted first, so that even a result returned in the same cycle
  // as its pixel would find its expectation already queued.
  always @(posedge clk_i) begin : toned_pixel_check
    toned_pixel_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        toned_pixel_q.push_back(predict_toned(pixel_red_i, pixel_green_i,
                                              pixel_blue_i, pixel_alpha_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (toned_pixel_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %02h %02h %02h %02h",
                   $time, toned_red_o, toned_green_o, toned_blue_o, toned_alpha_o);
        end else begin
          want = toned_pixel_q.pop_front();
          pixels_checked++;
          check_field("toned_red", want.red, toned_red_o);
          check_field("toned_green", want.green, toned_green_o);
          check_field("toned_blue", want.blue, toned_blue_o);
          check_field("toned_alpha", want.alpha, toned_alpha_o);
        end
      end
    end
  end

  // The receiver drops ready at random; stall_pct sets how often.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // A run that stops making progress ends here rather than hanging.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles at %0t", quiet_cycles, $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers. All of them are entered just after a rising edge and
  // return just after one, so every drive below is a nonblocking assignment
  // made at a rising edge.
  // --------------------------------------------------------------------------

  // APB write: setup, then access until pready completes it. The bus then
  // idles before the task returns so that the next caller drives a fresh edge.
  task automatic write_tone_reg(reg_idx_e idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_tone_write(idx, data);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one pixel. The idle gap before it is drawn cycle by cycle; each draw
  // extends it with chance idle_pct percent, up to MaxGap.
  // When there is no gap, valid simply stays high into the next pixel.
  task automatic send_pixel(logic [ChanW-1:0] red, logic [ChanW-1:0] green,
                            logic [ChanW-1:0] blue, logic [ChanW-1:0] alpha);
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_red_i   <= red;
    pixel_green_i <= green;
    pixel_blue_i  <= blue;
    pixel_alpha_i <= alpha;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    send_pixel(ChanW'($urandom_range(255)), ChanW'($urandom_range(255)),
               ChanW'($urandom_range(255)), ChanW'($urandom_range(255)));
  endtask

  // Drops valid after the last pixel of a phase and waits until the block
  // has returned everything and then lets the pipeline settle,
  // so that a register write never lands on a transaction in flight.
  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    while (toned_pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes all four registers. Upper data bits are filled with noise; the
  // block must ignore them.
  task automatic program_tone(logic [OffW-1:0] red_off, logic [OffW-1:0] green_off,
                              logic [OffW-1:0] blue_off, logic [ChanW-1:0] gray);
    logic [31:0] noise;
    noise = $urandom();
    write_tone_reg(REG_RED_OFF, {noise[31:OffW], red_off});
    noise = $urandom();
    write_tone_reg(REG_GREEN_OFF, {noise[31:OffW], green_off});
    noise = $urandom();
    write_tone_reg(REG_BLUE_OFF, {noise[31:OffW], blue_off});
    noise = $urandom();
    write_tone_reg(REG_GRAY, {noise[31:ChanW], gray});
  endtask

  // Offsets favor the edges: +255, -255 and the -256 pattern.
  function automatic logic [OffW-1:0] pick_offset();
    case ($urandom_range(5))
      0: return 9'h0ff;
      1: return 9'h101;
      2: return 9'h100;
      3: return 9'h000;
      default: return OffW'($urandom_range(511));
    endcase
  endfunction

  function automatic logic [ChanW-1:0] pick_gray();
    case ($urandom_range(5))
      0, 1: return 8'd0;
      2: return 8'd255;
      3: return 8'd1;
      default: return ChanW'($urandom_range(255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Straight after reset all registers are zero, so pixels must come back
  // unchanged.
  task automatic test_reset_tone();
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
    send_pixel(8'h5a, 8'ha5, 8'h3c, 8'hc3);
    drain_pixels();
  endtask

  // Plain offset mode at the extremes, where each channel saturates, and the
  // -256 offset pattern, the most negative value that the register holds.
  task automatic test_offset_saturation();
    program_tone(9'h0ff, 9'h101, 9'h100, 8'd0);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h80);
    send_pixel(8'hff, 8'hff, 8'hff, 8'h7f);
    send_pixel(8'h01, 8'hfe, 8'hff, 8'h00);
    drain_pixels();
    program_tone(9'h101, 9'h0ff, 9'h001, 8'd0);
    send_pixel(8'hff, 8'h00, 8'hfe, 8'hff);
    send_pixel(8'h80, 8'h80, 8'h80, 8'h55);
    drain_pixels();
  endtask

  // Desaturation: full gray, the smallest gray amount with offsets that push
  // the rounded result past both clamps, and a middle setting.
  task automatic test_gray_blend();
    program_tone(9'h000, 9'h000, 9'h000, 8'd255);
    send_pixel(8'hff, 8'h00, 8'h00, 8'h11);
    send_pixel(8'h00, 8'hff, 8'h00, 8'h22);
    send_pixel(8'h00, 8'h00, 8'hff, 8'h33);
    send_pixel(8'hff, 8'hff, 8'hff, 8'h44);
    drain_pixels();
    program_tone(9'h0ff, 9'h100, 9'h101, 8'd1);
    send_pixel(8'h00, 8'hff, 8'hff, 8'h00);
    send_pixel(8'hff, 8'h00, 8'h00, 8'hff);
    send_pixel(8'h11, 8'hc8, 8'h63, 8'h99);
    drain_pixels();
    program_tone(9'h010, 9'h1f0, 9'h000, 8'd128);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h01);
    send_pixel(8'hff, 8'h7f, 8'h00, 8'hfe);
    send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
    drain_pixels();
  endtask

  // Random pixels under four flow-control profiles, with two random register
  // settings in each profile.
  task automatic test_random_traffic();
    int idle_by_phase[4];
    int stall_by_phase[4];
    idle_by_phase  = '{0, 81, 0, 18};
    stall_by_phase = '{0, 0, 81, 18};
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      for (int setting = 0; setting < 2; setting++) begin
        program_tone(pick_offset(), pick_offset(), pick_offset(), pick_gray());
        repeat (100) send_random_pixel();
        drain_pixels();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, run the tests, then report.
  // --------------------------------------------------------------------------
  initial begin
    apply_tone_write(REG_RED_OFF, '0);
    apply_tone_write(REG_GREEN_OFF, '0);
    apply_tone_write(REG_BLUE_OFF, '0);
    apply_tone_write(REG_GRAY, '0);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_tone();
    test_offset_saturation();
    test_gray_blend();
    test_random_traffic();

    while (toned_pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d pixels and %0d register writes in offset and gray modes,",
             pixels_sent, reg_writes);
    $display("under free-running, sender-idle, receiver-stall and mixed flow; %0d checked.",
             pixels_checked);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
